// ----- hdl/kinetic_scroll_ramp_macros.svh -----
// Assertion macros shared by the kinetic_scroll_ramp RTL.
`ifndef KINETIC_SCROLL_RAMP_MACROS_SVH
`define KINETIC_SCROLL_RAMP_MACROS_SVH
`ifndef SYNTH
// checked only out of reset
`define KSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define KSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KSR_ASSERT(lbl, prop, msg)
`define KSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/ksr_pkg.sv -----
package ksr_pkg;

  localparam int POS_W     = 16;
  localparam int FINE_W    = 25;
  localparam int SPEED_W   = 14;
  localparam int STEP_W    = 7;
  localparam int CNT_W     = 2;
  localparam int MAG_W     = 14;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int LIM_W     = 34;
  localparam int LG_W      = 3;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [FINE_W-1:0]  FINE_MAX     = '1;
  localparam logic [SPEED_W-1:0] UNIT_SPEED   = 14'd256;
  localparam logic [SPEED_W-1:0] TOP_SPEED    = 14'd4096;
  localparam logic [STEP_W-1:0]  STEP_PRESS   = 7'd16;
  localparam logic [STEP_W-1:0]  STEP_RELEASE = 7'd64;
  localparam logic [STEP_W-1:0]  STEP_RESET   = 7'd1;
  localparam logic [CNT_W-1:0]   CNT_MAX      = 2'd3;
  localparam logic [POS_W-1:0]   LEN_RESET    = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_SET_POS = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAMP,
    ST_SQUARE,
    ST_BRAKE,
    ST_MOVE,
    ST_POS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic ramp;
    logic square;
    logic brake;
    logic move;
    logic pos;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic brake_more;
  } dp_status_t;

  // ramp steps are powers of two; returns the bit position of the step
  function automatic logic [LG_W-1:0] step_log2(input logic [STEP_W-1:0] a);
    logic [LG_W-1:0] lg;
    lg = '0;
    for (int i = 0; i < STEP_W; i++) begin
      if (a[i]) lg = LG_W'(i);
    end
    return lg;
  endfunction

endpackage

// ----- hdl/ksr_ctrl.sv -----
module ksr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ksr_pkg::dp_status_t status,
  output ksr_pkg::ctrl_cmd_t  cmd
);

  ksr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ksr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ksr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.tick_go ? ksr_pkg::ST_RAMP : ksr_pkg::ST_DONE;
        end
      end
      ksr_pkg::ST_RAMP: begin
        cmd.ramp  = 1'b1;
        state_nxt = ksr_pkg::ST_SQUARE;
      end
      ksr_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ksr_pkg::ST_BRAKE;
      end
      ksr_pkg::ST_BRAKE: begin
        // one speed cut per cycle until the braking distance fits
        if (status.brake_more) begin
          cmd.brake = 1'b1;
        end else begin
          state_nxt = ksr_pkg::ST_MOVE;
        end
      end
      ksr_pkg::ST_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = ksr_pkg::ST_POS;
      end
      ksr_pkg::ST_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = ksr_pkg::ST_DONE;
      end
      ksr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ksr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ksr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // nothing is taken while reset is held
  assign in_ready  = rst_n && (state_r == ksr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

`include "kinetic_scroll_ramp_macros.svh"

  `KSR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ksr_pkg::ST_IDLE) && !out_valid_r,
                     "reset did not idle the controller")
  `KSR_ASSERT(a_plain_op_done,
              in_valid && in_ready && !status.tick_go |=> state_r == ksr_pkg::ST_DONE,
              "non-tick item did not go straight to done")
  `KSR_ASSERT(a_brake_exit,
              (state_r == ksr_pkg::ST_BRAKE) && !status.brake_more |=> state_r == ksr_pkg::ST_MOVE,
              "brake loop left to wrong state")
  `KSR_ASSERT(a_no_overwrite, cmd.load_out |-> !out_valid_r || out_ready,
              "result loaded over an untaken result")
  `KSR_ASSERT(a_result_source, $rose(out_valid_r) |-> $past(state_r) == ksr_pkg::ST_DONE,
              "result appeared outside done")

endmodule

// ----- hdl/ksr_datapath.sv -----
module ksr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ksr_pkg::ctrl_cmd_t                  cmd,
  output ksr_pkg::dp_status_t                 status,
  input  logic [1:0]                          in_opcode,
  input  logic                                in_direction,
  input  logic [ksr_pkg::POS_W-1:0]           in_new_position,
  input  logic                                cfg_write,
  input  logic [ksr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ksr_pkg::POS_W-1:0]           cfg_data,
  output logic [ksr_pkg::POS_W-1:0]           out_position,
  output logic                                out_changed,
  output logic                                out_moving
);

  localparam int SW = ksr_pkg::SPEED_W;
  localparam int MW = ksr_pkg::MAG_W;
  localparam int FW = ksr_pkg::FINE_W;
  localparam int PW = ksr_pkg::POS_W;

  // architectural state
  logic [PW-1:0]                   total_len_r, window_len_r;
  logic [FW-1:0]                   fine_r;
  logic signed [SW-1:0]            speed_r, target_r;
  logic [ksr_pkg::STEP_W-1:0]      ramp_step_r;
  logic [ksr_pkg::CNT_W-1:0]       press_cnt_r;
  logic [PW-1:0]                   win_pos_r;
  logic                            ticking_r;
  logic                            changed_r;

  // per-tick working registers
  logic [PW-1:0]                   range_r;
  logic                            neg_r;
  logic [MW-1:0]                   m_r;
  logic [ksr_pkg::SQ_W-1:0]        sq_r;
  logic [ksr_pkg::LIM_W-1:0]       lim_r;
  logic                            dist_ok_r;
  logic [ksr_pkg::LG_W-1:0]        lg_r;

  logic [PW-1:0]                   out_position_r;
  logic                            out_changed_r, out_moving_r;

  ksr_pkg::opcode_t                op_c;
  logic [PW-1:0]                   win_eff_c, range_c;

  assign op_c      = ksr_pkg::opcode_t'(in_opcode);
  assign win_eff_c = (window_len_r < total_len_r) ? window_len_r : total_len_r;
  assign range_c   = total_len_r - win_eff_c;

  // speed ramp toward target
  logic signed [SW:0] s_ext, t_ext, a_ext, up_c, dn_c, ramp_c;
  assign s_ext = {speed_r[SW-1], speed_r};
  assign t_ext = {target_r[SW-1], target_r};
  assign a_ext = {{(SW + 1 - ksr_pkg::STEP_W){1'b0}}, ramp_step_r};
  assign up_c  = s_ext + a_ext;
  assign dn_c  = s_ext - a_ext;

  always_comb begin
    if (s_ext < t_ext) begin
      ramp_c = (up_c > t_ext) ? t_ext : up_c;
    end else if (s_ext > t_ext) begin
      ramp_c = (dn_c < t_ext) ? t_ext : dn_c;
    end else begin
      ramp_c = s_ext;
    end
  end

  // square of speed and the braking limit dist * 4 * step
  logic [MW-1:0]                   mag_c;
  logic [ksr_pkg::SQ_W-1:0]        sq_c;
  logic signed [FW:0]              room_c;
  logic                            room_pos_c, dist_ok_c;
  logic [FW-1:0]                   dist_c;
  logic [ksr_pkg::LG_W-1:0]        lg_c;
  logic [ksr_pkg::LIM_W-1:0]       lim_c;

  assign mag_c      = speed_r[SW-1] ? MW'(-speed_r) : MW'(speed_r);
  assign sq_c       = mag_c * mag_c;
  assign room_c     = $signed({1'b0, range_r, {ksr_pkg::FRAC_BITS{1'b0}}})
                      - $signed({1'b0, fine_r});
  assign room_pos_c = !room_c[FW] && (room_c != '0);
  assign dist_c     = speed_r[SW-1] ? fine_r : room_c[FW-1:0];
  assign dist_ok_c  = speed_r[SW-1] ? (fine_r != '0) : room_pos_c;
  assign lg_c       = ksr_pkg::step_log2(ramp_step_r);
  assign lim_c      = ksr_pkg::LIM_W'(dist_c) << ({1'b0, lg_c} + 4'd2);

  // brake step: (m - d)^2 = m^2 - 2*m*d + d^2, d = 4 * step
  logic [MW-1:0]                   d_c, m_step_c;
  logic [ksr_pkg::SQ_W-1:0]        sq_step_c;
  logic                            m_big_c;
  logic [3:0]                      sh_md_c;
  logic [4:0]                      sh_dd_c;

  assign d_c       = MW'(1) << ({1'b0, lg_r} + 4'd2);
  assign sh_md_c   = {1'b0, lg_r} + 4'd3;
  assign sh_dd_c   = {1'b0, lg_r, 1'b0} + 5'd4;
  assign m_big_c   = m_r > d_c;
  assign m_step_c  = m_big_c ? (m_r - d_c) : '0;
  assign sq_step_c = m_big_c ? (sq_r - (ksr_pkg::SQ_W'(m_r) << sh_md_c)
                                + (ksr_pkg::SQ_W'(1) << sh_dd_c)) : '0;

  assign status.brake_more = dist_ok_r && (m_r != '0)
                             && ({{(ksr_pkg::LIM_W - ksr_pkg::SQ_W){1'b0}}, sq_r} > lim_r);
  assign status.tick_go    = (op_c == ksr_pkg::OP_TICK) && ticking_r;

  // position advance
  logic signed [MW:0]   s_fin_c;
  logic signed [FW+1:0] fsum_c;
  logic [FW-1:0]        fine_nxt;

  assign s_fin_c = neg_r ? -$signed({1'b0, m_r}) : $signed({1'b0, m_r});
  assign fsum_c  = $signed({2'b00, fine_r}) + (FW + 2)'(s_fin_c);

  always_comb begin
    if (fsum_c[FW+1]) begin
      fine_nxt = '0;
    end else if (fsum_c[FW]) begin
      fine_nxt = ksr_pkg::FINE_MAX;
    end else begin
      fine_nxt = fsum_c[FW-1:0];
    end
  end

  logic [FW-ksr_pkg::FRAC_BITS-1:0] np_c;
  logic [PW-1:0]                    win_pos_nxt;
  assign np_c        = fine_r[FW-1:ksr_pkg::FRAC_BITS];
  assign win_pos_nxt = (np_c > {1'b0, range_r}) ? range_r : np_c[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_len_r  <= ksr_pkg::LEN_RESET;
      window_len_r <= ksr_pkg::LEN_RESET;
      fine_r       <= '0;
      speed_r      <= '0;
      target_r     <= '0;
      ramp_step_r  <= ksr_pkg::STEP_RESET;
      press_cnt_r  <= '0;
      win_pos_r    <= '0;
      ticking_r    <= 1'b0;
      changed_r    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ksr_pkg::REG_TOTAL_LENGTH:  total_len_r  <= cfg_data;
          ksr_pkg::REG_WINDOW_LENGTH: window_len_r <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.accept) begin
        changed_r <= 1'b0;
        case (op_c)
          ksr_pkg::OP_PRESS: begin
            if (press_cnt_r != ksr_pkg::CNT_MAX) press_cnt_r <= press_cnt_r + 1'b1;
            if (press_cnt_r == '0) begin
              speed_r     <= in_direction ? $signed(ksr_pkg::UNIT_SPEED)
                                          : -$signed(ksr_pkg::UNIT_SPEED);
              target_r    <= in_direction ? $signed(ksr_pkg::TOP_SPEED)
                                          : -$signed(ksr_pkg::TOP_SPEED);
              ramp_step_r <= ksr_pkg::STEP_PRESS;
              fine_r      <= FW'({win_pos_r, {ksr_pkg::FRAC_BITS{1'b0}}});
              ticking_r   <= 1'b1;
            end
          end
          ksr_pkg::OP_RELEASE: begin
            if (press_cnt_r != '0) begin
              press_cnt_r <= press_cnt_r - 1'b1;
              // last key up starts braking
              if (press_cnt_r == ksr_pkg::CNT_W'(1)) begin
                ramp_step_r <= ksr_pkg::STEP_RELEASE;
                target_r    <= '0;
              end
            end
          end
          ksr_pkg::OP_SET_POS: begin
            win_pos_r <= (in_new_position > range_c) ? range_c : in_new_position;
          end
          default: ;
        endcase
      end

      if (cmd.ramp) begin
        speed_r <= ramp_c[SW-1:0];
      end

      if (cmd.move) begin
        fine_r    <= fine_nxt;
        speed_r   <= s_fin_c[SW-1:0];
        ticking_r <= (m_r != '0);
      end

      if (cmd.pos) begin
        win_pos_r <= win_pos_nxt;
        changed_r <= (win_pos_nxt != win_pos_r);
      end
    end
  end

  // working and output registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.ramp) begin
      range_r <= range_c;
    end
    if (cmd.square) begin
      neg_r     <= speed_r[SW-1];
      m_r       <= mag_c;
      sq_r      <= sq_c;
      lim_r     <= lim_c;
      dist_ok_r <= dist_ok_c;
      lg_r      <= lg_c;
    end else if (cmd.brake) begin
      m_r  <= m_step_c;
      sq_r <= sq_step_c;
    end
    if (cmd.load_out) begin
      out_position_r <= win_pos_r;
      out_changed_r  <= changed_r;
      out_moving_r   <= ticking_r;
    end
  end

  assign out_position = out_position_r;
  assign out_changed  = out_changed_r;
  assign out_moving   = out_moving_r;

`include "kinetic_scroll_ramp_macros.svh"

  `KSR_ASSERT(a_brake_shrinks, cmd.brake |=> m_r < $past(m_r),
              "brake step did not reduce speed")
  `KSR_ASSERT(a_ticking_tracks_speed, $past(cmd.move) |-> ticking_r == (speed_r != '0),
              "ticking disagrees with speed after move")
  `KSR_ASSERT(a_sq_exact, cmd.brake |=> sq_r == m_r * m_r,
              "running square lost track of speed")

endmodule

// ----- hdl/kinetic_scroll_ramp.sv -----
// kinetic_scroll_ramp: one result item per input item.
// Press, release, set position and idle ticks: from accept straight to the done state.
// Active tick: ramp, square, brake (n cuts, 0..64, one per cycle), move, position, done.
// Next item is taken once the previous one is in the output register, never before;
// a result waits in done while the output register is full and out_ready is low.
// rst_n is synchronous, active low: clears motion state, lengths return to 100.
module kinetic_scroll_ramp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic                               in_direction,
  input  logic [ksr_pkg::POS_W-1:0]          in_new_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ksr_pkg::POS_W-1:0]          out_position,
  output logic                               out_changed,
  output logic                               out_moving,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ksr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ksr_pkg::POS_W-1:0]          cfg_data
);

  ksr_pkg::ctrl_cmd_t  cmd;
  ksr_pkg::dp_status_t status;

  // writes during reset would be overridden, so none are taken
  assign cfg_ready = rst_n;

  ksr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ksr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (in_opcode),
    .in_direction    (in_direction),
    .in_new_position (in_new_position),
    .cfg_write       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_position    (out_position),
    .out_changed     (out_changed),
    .out_moving      (out_moving)
  );

endmodule

// ----- dv/tb.sv -----
module tb;

  localparam int HANG_LIMIT = 2000;
  localparam int BRAKE_GAIN = 4;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 105;

  typedef struct packed {
    ksr_pkg::opcode_t          op;
    logic                      dir;
    logic [ksr_pkg::POS_W-1:0] req;
  } scroll_in_t;

  typedef struct packed {
    logic [ksr_pkg::POS_W-1:0] position;
    logic                      changed;
    logic                      moving;
  } scroll_out_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_opcode = 2'd0;
  logic                          in_direction = 1'b0;
  logic [ksr_pkg::POS_W-1:0]     in_new_position = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ksr_pkg::POS_W-1:0]     out_position;
  logic                          out_changed;
  logic                          out_moving;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ksr_pkg::CFG_IDX_W-1:0] cfg_index = ksr_pkg::REG_TOTAL_LENGTH;
  logic [ksr_pkg::POS_W-1:0]     cfg_data = '0;

  kinetic_scroll_ramp DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_direction    (in_direction),
    .in_new_position (in_new_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .out_changed     (out_changed),
    .out_moving      (out_moving),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // scroll state mirror
  logic [ksr_pkg::POS_W-1:0]          total_len;
  logic [ksr_pkg::POS_W-1:0]          win_len;
  logic [ksr_pkg::FINE_W-1:0]         fine_pos;
  logic signed [ksr_pkg::SPEED_W-1:0] velocity;
  logic signed [ksr_pkg::SPEED_W-1:0] goal_velocity;
  logic [ksr_pkg::STEP_W-1:0]         accel;
  logic [ksr_pkg::CNT_W-1:0]          held_keys;
  logic [ksr_pkg::POS_W-1:0]          scroll_pos;
  logic                               coasting;

  scroll_in_t  feed_q[$];
  scroll_out_t expected_scroll[$];

  int errors = 0;
  int queued = 0;
  int items_done = 0;
  int results_seen = 0;
  int busy_ticks = 0;
  int brake_cuts = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet = 0;
  bit held_long = 1'b0;
  bit steady_tail = 1'b0;

  int unsigned total_set[PHASES] = '{1000, 65535, 0, 200, 65535, 300};
  int unsigned window_set[PHASES] = '{100, 0, 65535, 150, 65535, 0};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_scroll_state();
    total_len     = ksr_pkg::LEN_RESET;
    win_len       = ksr_pkg::LEN_RESET;
    fine_pos      = '0;
    velocity      = '0;
    goal_velocity = '0;
    accel         = ksr_pkg::STEP_RESET;
    held_keys     = '0;
    scroll_pos    = '0;
    coasting      = 1'b0;
  endfunction

  function automatic longint view_span();
    logic [ksr_pkg::POS_W-1:0] w;
    w = (win_len < total_len) ? win_len : total_len;
    return longint'(total_len - w);
  endfunction

  // one tick of motion: ramp, brake toward the boundary ahead, advance
  function automatic logic glide_tick();
    longint a, s, g, f, r, room, np;
    logic [ksr_pkg::POS_W-1:0] prev;
    a = longint'(accel);
    s = longint'(velocity);
    g = longint'(goal_velocity);
    f = longint'(fine_pos);
    r = view_span();
    prev = scroll_pos;
    if (s < g) begin
      s += a;
      if (s > g) s = g;
    end
    if (s > g) begin
      s -= a;
      if (s < g) s = g;
    end
    while (s < 0 && f > 0 && s * s > f * a * BRAKE_GAIN) begin
      s += a * BRAKE_GAIN;
      if (s > 0) s = 0;
      brake_cuts++;
    end
    room = (r << ksr_pkg::FRAC_BITS) - f;
    while (s > 0 && room > 0 && s * s > room * a * BRAKE_GAIN) begin
      s -= a * BRAKE_GAIN;
      if (s < 0) s = 0;
      brake_cuts++;
    end
    f += s;
    if (f < 0) f = 0;
    if (f > longint'(ksr_pkg::FINE_MAX)) f = longint'(ksr_pkg::FINE_MAX);
    np = f >>> ksr_pkg::FRAC_BITS;
    if (np > r) np = r;
    velocity   = ksr_pkg::SPEED_W'(s);
    fine_pos   = ksr_pkg::FINE_W'(f);
    scroll_pos = ksr_pkg::POS_W'(np);
    coasting   = (s != 0);
    return scroll_pos != prev;
  endfunction

  function automatic scroll_out_t scroll_step(input scroll_in_t it);
    scroll_out_t res;
    logic moved;
    moved = 1'b0;
    case (it.op)
      ksr_pkg::OP_TICK: begin
        if (coasting) moved = glide_tick();
      end
      ksr_pkg::OP_PRESS: begin
        if (held_keys != ksr_pkg::CNT_MAX) held_keys++;
        if (held_keys == 1) begin
          velocity      = it.dir ? $signed(ksr_pkg::UNIT_SPEED)
                                 : -$signed(ksr_pkg::UNIT_SPEED);
          goal_velocity = it.dir ? $signed(ksr_pkg::TOP_SPEED)
                                 : -$signed(ksr_pkg::TOP_SPEED);
          accel         = ksr_pkg::STEP_PRESS;
          fine_pos      = ksr_pkg::FINE_W'(scroll_pos) << ksr_pkg::FRAC_BITS;
          coasting      = 1'b1;
        end
      end
      ksr_pkg::OP_RELEASE: begin
        if (held_keys != 0) begin
          held_keys--;
          if (held_keys == 0) begin
            accel         = ksr_pkg::STEP_RELEASE;
            goal_velocity = '0;
          end
        end
      end
      ksr_pkg::OP_SET_POS: begin
        scroll_pos = (longint'(it.req) > view_span()) ? ksr_pkg::POS_W'(view_span())
                                                      : it.req;
      end
      default: ;
    endcase
    res.position = scroll_pos;
    res.changed  = moved;
    res.moving   = coasting;
    return res;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, fname, want, got);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (ksr_pkg::opcode_t'(in_opcode) == ksr_pkg::OP_TICK && coasting) busy_ticks++;
        expected_scroll.push_back(scroll_step(
            '{op: ksr_pkg::opcode_t'(in_opcode), dir: in_direction, req: in_new_position}));
        items_done++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (feed_q.size() != 0) begin
          in_opcode       <= feed_q[0].op;
          in_direction    <= feed_q[0].dir;
          in_new_position <= feed_q[0].req;
          in_valid        <= 1'b1;
          void'(feed_q.pop_front());
          if (!steady_tail && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    scroll_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_scroll.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending, position %0d", $time, out_position);
        end else begin
          want = expected_scroll.pop_front();
          check_field("position", want.position, out_position);
          check_field("changed", want.changed, out_changed);
          check_field("moving", want.moving, out_moving);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (!held_long && results_seen >= 120) begin
        // long hold so the block backs up and stalls its input
        held_long = 1'b1;
        stall_left = 300;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet == HANG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_scroll.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic push_item(input ksr_pkg::opcode_t op, input logic dir,
                           input logic [ksr_pkg::POS_W-1:0] req);
    feed_q.push_back('{op: op, dir: dir, req: req});
    queued++;
  endtask

  task automatic write_reg(input logic [ksr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ksr_pkg::POS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ksr_pkg::REG_TOTAL_LENGTH) total_len = val;
    else win_len = val;
  endtask

  task automatic drain();
    while (feed_q.size() != 0 || in_valid || expected_scroll.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [ksr_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(0, 1) == 0) return ksr_pkg::POS_W'($urandom);
    return ksr_pkg::POS_W'($urandom_range(0, int'(view_span())));
  endfunction

  // press, hold for a while, release, then tick while it coasts
  task automatic add_glide();
    int hold, coast;
    logic dir;
    dir   = $urandom_range(0, 1);
    hold  = $urandom_range(1, 40);
    coast = $urandom_range(1, 70);
    if ($urandom_range(0, 2) == 0)
      push_item(ksr_pkg::OP_SET_POS, $urandom_range(0, 1), pick_position());
    push_item(ksr_pkg::OP_PRESS, dir, ksr_pkg::POS_W'($urandom));
    repeat (hold) begin
      push_item(ksr_pkg::OP_TICK, $urandom_range(0, 1), ksr_pkg::POS_W'($urandom));
      case ($urandom_range(0, 39))
        0, 1: begin
          push_item(ksr_pkg::OP_PRESS, $urandom_range(0, 1), ksr_pkg::POS_W'($urandom));
          push_item(ksr_pkg::OP_RELEASE, $urandom_range(0, 1), ksr_pkg::POS_W'($urandom));
        end
        2: push_item(ksr_pkg::OP_SET_POS, $urandom_range(0, 1), pick_position());
        3: push_item(ksr_pkg::OP_RELEASE, $urandom_range(0, 1), ksr_pkg::POS_W'($urandom));
        default: ;
      endcase
    end
    push_item(ksr_pkg::OP_RELEASE, $urandom_range(0, 1), ksr_pkg::POS_W'($urandom));
    repeat (coast)
      push_item(ksr_pkg::OP_TICK, $urandom_range(0, 1), ksr_pkg::POS_W'($urandom));
  endtask

  task automatic add_directed();
    push_item(ksr_pkg::OP_TICK, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_RELEASE, 1'b1, 16'd0);
    push_item(ksr_pkg::OP_SET_POS, 1'b1, 16'hFFFF);
    push_item(ksr_pkg::OP_SET_POS, 1'b0, 16'd0);
    // pressing toward the start at position 0 pins the fine position at zero
    push_item(ksr_pkg::OP_PRESS, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_TICK, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_RELEASE, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_TICK, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_TICK, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_SET_POS, 1'b0, 16'd450);
    push_item(ksr_pkg::OP_PRESS, 1'b1, 16'd0);
    push_item(ksr_pkg::OP_PRESS, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_PRESS, 1'b1, 16'd0);
    push_item(ksr_pkg::OP_PRESS, 1'b1, 16'd0);
    push_item(ksr_pkg::OP_TICK, 1'b1, 16'hFFFF);
    push_item(ksr_pkg::OP_TICK, 1'b1, 16'hFFFF);
    push_item(ksr_pkg::OP_RELEASE, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_RELEASE, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_RELEASE, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_SET_POS, 1'b0, 16'd899);
    push_item(ksr_pkg::OP_TICK, 1'b0, 16'd0);
    push_item(ksr_pkg::OP_TICK, 1'b0, 16'd0);
  endtask

  initial begin
    int goal;
    reset_scroll_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(ksr_pkg::REG_TOTAL_LENGTH, ksr_pkg::POS_W'(total_set[p]));
      write_reg(ksr_pkg::REG_WINDOW_LENGTH, ksr_pkg::POS_W'(window_set[p]));
      if (p == 0) add_directed();
      if (p == PHASES - 1) steady_tail = 1'b1;
      goal = queued + PHASE_ITEMS;
      while (queued < goal) begin
        if ($urandom_range(0, 3) != 0)
          add_glide();
        else
          push_item(ksr_pkg::opcode_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                    ksr_pkg::POS_W'($urandom));
      end
      drain();
    end
    repeat (80) @(posedge clk);
    $display("tb: %0d items checked across %0d length settings", items_done, PHASES);
    $display("tb: %0d ticks in motion, %0d braking cuts", busy_ticks, brake_cuts);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
